@@ rtl/tbhc_pkg.sv @@
// tbhc_pkg: shared types and constants for the traction/brake handle controller
// holds the tick, configuration and controller state structs plus mode codes
// no dependencies
package tbhc_pkg;

    // handle mode codes, 2-bit two's complement
    localparam logic signed [1:0] MODE_EMERG    = 2'b10;
    localparam logic signed [1:0] MODE_BRAKE    = 2'b11;
    localparam logic signed [1:0] MODE_NEUTRAL  = 2'b00;
    localparam logic signed [1:0] MODE_TRACTION = 2'b01;

    // configuration register indexes
    localparam logic [1:0] REG_TRACTION_MIN   = 2'd0;
    localparam logic [1:0] REG_BRAKE_OFFSET   = 2'd1;
    localparam logic [1:0] REG_HIGH_SPEED     = 2'd2;
    localparam logic [1:0] REG_REPEAT_TICKS   = 2'd3;

    // level constants
    localparam logic [6:0] LEVEL_FULL  = 7'd100;
    localparam logic [6:0] LEVEL_EMERG = 7'd90;

    typedef struct packed {
        logic up;
        logic down;
        logic shift;
        logic ctrl;
        logic fwd;
        logic bwd;
    } tick_t;

    typedef struct packed {
        logic [6:0]  traction_min;
        logic [6:0]  brake_offset;
        logic [6:0]  high_speed_step;
        logic [15:0] repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [1:0] mode;
        logic [6:0]        trac_pct;
        logic [6:0]        brake_pct;
        logic signed [1:0] reverser;
        logic signed [7:0] motion_speed;
        logic              brake_armed;
        logic              trac_armed;
        logic              prev_fwd;
        logic              prev_bwd;
        logic              prev_up;
        logic              prev_down;
        logic [15:0]       brake_count;
        logic [15:0]       trac_count;
        logic              brake_running;
        logic              trac_running;
    } ctl_state_t;

endpackage

@@ rtl/tbhc_next.sv @@
// tbhc_next: combinational next-state logic for one control tick
// computes mode, levels, reverser, repeat timers and the combined handle position
// depends on tbhc_pkg
module tbhc_next
    import tbhc_pkg::*;
(
    input  ctl_state_t        cur,
    input  cfg_t              cfg,
    input  tick_t             tick,
    output ctl_state_t        nxt,
    output logic signed [7:0] position
);

    // repeat timer step: {fire, new count}
    function automatic logic [16:0] timer_step(input logic running,
                                                input logic [15:0] count,
                                                input logic [15:0] limit);
        logic [16:0] inc;
        inc = {1'b0, count} + 17'd1;
        if (!running) begin
            return {1'b0, count};
        end
        if (inc >= {1'b0, limit}) begin
            return {1'b1, 16'd0};
        end
        return {1'b0, inc[15:0]};
    endfunction

    // level plus delta, clamped to 0 .. ceiling
    function automatic logic [6:0] clamp_level(input logic [6:0] level,
                                                input logic signed [7:0] delta,
                                                input logic [6:0] ceiling);
        logic signed [8:0] v;
        v = $signed({2'b00, level}) + $signed({delta[7], delta});
        if (v < 0) begin
            return 7'd0;
        end
        if (v > $signed({2'b00, ceiling})) begin
            return ceiling;
        end
        return v[6:0];
    endfunction

    // signed level change for a timer fire in the given mode
    function automatic logic signed [7:0] mode_delta(input logic signed [1:0] mode,
                                                     input logic signed [7:0] speed);
        if (mode == MODE_BRAKE) begin
            return -speed;
        end
        if (mode == MODE_TRACTION) begin
            return speed;
        end
        return 8'sd0;
    endfunction

    logic [15:0]       limit;
    logic [6:0]        trac_ceil;
    logic [6:0]        brake_ceil;
    logic signed [7:0] step;
    logic [16:0]       tres;
    logic              old_up;
    logic              old_down;
    ctl_state_t        s;

    // effective timer limit, step size and level ceilings
    always_comb begin
        limit      = (cfg.repeat_ticks == 16'd0) ? 16'd1 : cfg.repeat_ticks;
        trac_ceil  = (cfg.traction_min > LEVEL_FULL) ? 7'd0 : LEVEL_FULL - cfg.traction_min;
        brake_ceil = (cfg.brake_offset > LEVEL_FULL) ? 7'd0 : LEVEL_FULL - cfg.brake_offset;
        step       = tick.shift ? $signed({1'b0, cfg.high_speed_step}) : 8'sd1;
    end

    // one tick of the handle controller, evaluated in program order
    always_comb begin
        s        = cur;
        tres     = 17'd0;
        old_up   = cur.prev_up;
        old_down = cur.prev_down;

        // reverser steps on rising key edges
        if (tick.fwd && !cur.prev_fwd && s.reverser < 2'sd1) begin
            s.reverser = s.reverser + 2'sd1;
        end
        if (tick.bwd && !cur.prev_bwd && s.reverser > -2'sd1) begin
            s.reverser = s.reverser - 2'sd1;
        end
        s.prev_fwd = tick.fwd;
        s.prev_bwd = tick.bwd;

        if (tick.ctrl && tick.down) begin
            // return to neutral, timers left as they are
            s.mode         = MODE_NEUTRAL;
            s.motion_speed = 8'sd0;
            s.brake_armed  = 1'b0;
            s.trac_armed   = 1'b0;
            s.brake_pct    = 7'd0;
            s.trac_pct     = 7'd0;
            s.prev_up      = 1'b1;
            s.prev_down    = 1'b1;
        end else if (s.mode == MODE_EMERG) begin
            // release from emergency back to brake
            if (tick.up) begin
                s.mode      = MODE_BRAKE;
                s.brake_pct = LEVEL_EMERG;
            end
        end else begin
            // neutral: new presses pick brake or traction
            if (s.mode == MODE_NEUTRAL) begin
                s.trac_pct  = 7'd0;
                s.brake_pct = 7'd0;
                if (tick.down && !old_down) begin
                    s.mode        = s.mode - 2'sd1;
                    s.brake_armed = 1'b0;
                end
                if (tick.up && !old_up) begin
                    s.mode       = s.mode + 2'sd1;
                    s.trac_armed = 1'b0;
                end
            end

            // brake mode
            if (s.mode == MODE_BRAKE) begin
                s.trac_armed = 1'b0;
                if (!s.brake_running) begin
                    s.brake_running = 1'b1;
                    s.brake_count   = 16'd0;
                end
                if (tick.up) begin
                    if (s.brake_pct == 7'd0) begin
                        s.mode          = MODE_NEUTRAL;
                        s.brake_running = 1'b0;
                        s.brake_count   = 16'd0;
                        s.brake_armed   = 1'b0;
                        s.motion_speed  = 8'sd0;
                    end else begin
                        s.motion_speed = step;
                    end
                    tres          = timer_step(s.brake_running, s.brake_count, limit);
                    s.brake_count = tres[15:0];
                    if (tres[16]) begin
                        s.brake_pct = clamp_level(s.brake_pct,
                                                  mode_delta(s.mode, s.motion_speed),
                                                  brake_ceil);
                    end
                end
                if (tick.down) begin
                    s.motion_speed = s.brake_armed ? -step : 8'sd0;
                    if (s.brake_pct == LEVEL_EMERG && !old_down) begin
                        s.mode          = MODE_EMERG;
                        s.brake_running = 1'b0;
                        s.brake_count   = 16'd0;
                    end
                    tres          = timer_step(s.brake_running, s.brake_count, limit);
                    s.brake_count = tres[15:0];
                    if (tres[16]) begin
                        s.brake_pct = clamp_level(s.brake_pct,
                                                  mode_delta(s.mode, s.motion_speed),
                                                  brake_ceil);
                    end
                end else begin
                    s.brake_armed = 1'b1;
                end
            end

            // traction mode
            if (s.mode == MODE_TRACTION) begin
                s.brake_armed = 1'b0;
                if (!s.trac_running) begin
                    s.trac_running = 1'b1;
                    s.trac_count   = 16'd0;
                end
                if (tick.down) begin
                    if (s.trac_pct == 7'd0) begin
                        s.mode         = MODE_NEUTRAL;
                        s.trac_running = 1'b0;
                        s.trac_count   = 16'd0;
                        s.trac_armed   = 1'b0;
                        s.motion_speed = 8'sd0;
                    end else begin
                        s.motion_speed = -step;
                    end
                    tres         = timer_step(s.trac_running, s.trac_count, limit);
                    s.trac_count = tres[15:0];
                    if (tres[16]) begin
                        s.trac_pct = clamp_level(s.trac_pct,
                                                 mode_delta(s.mode, s.motion_speed),
                                                 trac_ceil);
                    end
                end
                if (tick.up) begin
                    s.motion_speed = s.trac_armed ? step : 8'sd0;
                    tres         = timer_step(s.trac_running, s.trac_count, limit);
                    s.trac_count = tres[15:0];
                    if (tres[16]) begin
                        s.trac_pct = clamp_level(s.trac_pct,
                                                 mode_delta(s.mode, s.motion_speed),
                                                 trac_ceil);
                    end
                end else begin
                    s.trac_armed = 1'b1;
                end
            end

            s.prev_up   = tick.up;
            s.prev_down = tick.down;
        end

        nxt = s;
    end

    // combined handle position: mode * 10 + traction - brake
    always_comb begin
        position = ($signed({{6{nxt.mode[1]}}, nxt.mode}) * 8'sd10)
                 + $signed({1'b0, nxt.trac_pct})
                 - $signed({1'b0, nxt.brake_pct});
    end

endmodule

@@ rtl/traction_brake_handle_controller_core.sv @@
// traction_brake_handle_controller_core: top level of the handle controller
// result: an accepted tick is registered and shows on the m_ side in the cycle after acceptance
// throughput: one tick per cycle while m_ready is high; the result register is released by m_ready
// reset: synchronous active-low aresetn clears the controller state, the
// configuration registers to their defaults and the result valid flag
// depends on tbhc_pkg and tbhc_next
module traction_brake_handle_controller_core
    import tbhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    // tick input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_up_button,
    input  logic              s_down_button,
    input  logic              s_shift_held,
    input  logic              s_ctrl_held,
    input  logic              s_reverse_fwd,
    input  logic              s_reverse_bwd,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [1:0] m_handle_mode,
    output logic [6:0]        m_traction_level,
    output logic [6:0]        m_braking_level,
    output logic signed [1:0] m_reverser_position,
    output logic signed [7:0] m_handle_position,
    output logic              m_emergency_active
);

    cfg_t              cfg_reg;
    ctl_state_t        state_reg;
    ctl_state_t        state_next;
    tick_t             tick;
    logic signed [7:0] position_next;
    logic              m_valid_reg;
    logic signed [1:0] mode_out_reg;
    logic [6:0]        trac_out_reg;
    logic [6:0]        brake_out_reg;
    logic signed [1:0] rev_out_reg;
    logic signed [7:0] pos_out_reg;
    logic              emerg_out_reg;
    logic              accept;

    // transaction handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign tick = '{up:    s_up_button,
                    down:  s_down_button,
                    shift: s_shift_held,
                    ctrl:  s_ctrl_held,
                    fwd:   s_reverse_fwd,
                    bwd:   s_reverse_bwd};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.traction_min    <= 7'd0;
            cfg_reg.brake_offset    <= 7'd0;
            cfg_reg.high_speed_step <= 7'd1;
            cfg_reg.repeat_ticks    <= 16'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TRACTION_MIN: cfg_reg.traction_min    <= cfg_wdata[6:0];
                REG_BRAKE_OFFSET: cfg_reg.brake_offset    <= cfg_wdata[6:0];
                REG_HIGH_SPEED:   cfg_reg.high_speed_step <= cfg_wdata[6:0];
                REG_REPEAT_TICKS: cfg_reg.repeat_ticks    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // per-tick next state
    tbhc_next u_next (
        .cur      (state_reg),
        .cfg      (cfg_reg),
        .tick     (tick),
        .nxt      (state_next),
        .position (position_next)
    );

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_out_reg  <= state_next.mode;
            trac_out_reg  <= state_next.trac_pct;
            brake_out_reg <= state_next.brake_pct;
            rev_out_reg   <= state_next.reverser;
            pos_out_reg   <= position_next;
            emerg_out_reg <= (state_next.mode == MODE_EMERG);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_handle_mode       = mode_out_reg;
    assign m_traction_level    = trac_out_reg;
    assign m_braking_level     = brake_out_reg;
    assign m_reverser_position = rev_out_reg;
    assign m_handle_position   = pos_out_reg;
    assign m_emergency_active  = emerg_out_reg;

endmodule

@@ rtl/tbhc_checker.sv @@
// tbhc_checker: port-level assertions for the handle controller
// bound to traction_brake_handle_controller_core; depends on tbhc_pkg
module tbhc_checker
    import tbhc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_up_button,
    input logic              s_down_button,
    input logic              s_shift_held,
    input logic              s_ctrl_held,
    input logic              s_reverse_fwd,
    input logic              s_reverse_bwd,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [1:0] m_handle_mode,
    input logic [6:0]        m_traction_level,
    input logic [6:0]        m_braking_level,
    input logic signed [1:0] m_reverser_position,
    input logic signed [7:0] m_handle_position,
    input logic              m_emergency_active
);

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_up_button) && $stable(s_down_button)
            && $stable(s_shift_held) && $stable(s_ctrl_held)
            && $stable(s_reverse_fwd) && $stable(s_reverse_bwd))
        else $error("waiting input changed");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_handle_mode)
            && $stable(m_handle_position) && $stable(m_reverser_position))
        else $error("stalled result changed");

    // emergency flag follows the mode
    a_emerg_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_emergency_active == (m_handle_mode == MODE_EMERG)))
        else $error("emergency flag does not match mode");

    // combined position agrees with mode and levels
    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_handle_position == ($signed({{6{m_handle_mode[1]}}, m_handle_mode})
            * 8'sd10 + $signed({1'b0, m_traction_level})
            - $signed({1'b0, m_braking_level}))))
        else $error("handle position mismatch");

    // traction and brake are never both applied
    a_levels_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_traction_level == 7'd0 || m_braking_level == 7'd0))
        else $error("traction and brake levels both nonzero");

endmodule

bind traction_brake_handle_controller_core tbhc_checker u_tbhc_checker (.*);
